// File: hw/rtl/dxt_pkg.sv
// Shared types, constants and arithmetic helpers for the DXT block decoder.
// Used by dxt_front, dxt_queue, dxt_back and dxt_texture_block_decoder.
`default_nettype none

package dxt_pkg;

	// Queue depth between the front and back halves
	localparam int QUEUE_DEPTH = 2;

	// Field masks of the RGB565 endpoint fields and the opaque and clear alpha values
	localparam logic [4:0] MASK5 = 5'h1F;
	localparam logic [5:0] MASK6 = 6'h3F;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] ALPHA_CLEAR = 8'd0;

	// Index of the final row of a block; the final row raises tlast
	localparam logic [1:0] ROW_LAST = 2'd3;

	// Reciprocal multipliers: floor(x/3) for x < 768, floor(x/7) for x < 1792, floor(x/5) for x < 1280
	localparam logic [9:0] RECIP3 = 10'd683;
	localparam logic [11:0] RECIP7 = 12'd2341;
	localparam logic [11:0] RECIP5 = 12'd3277;

	// One texel channel set, element 0 = R, 1 = G, 2 = B
	typedef logic [2:0][7:0] rgb_t;

	// One decoded block as it waits in the queue
	typedef struct packed {
		logic alpha_mode;
		logic [47:0] aidx;
		logic [31:0] cidx;
		logic [7:0][7:0] ramp;
		logic [3:0][31:0] pal;
	} entry_t;

	// Bit-replicating widen of an RGB565 colour
	function automatic rgb_t widen565(input logic [15:0] c);
		logic [4:0] r;
		logic [5:0] g;
		logic [4:0] b;
		rgb_t res;
		r = c[15:11] & MASK5;
		g = c[10:5] & MASK6;
		b = c[4:0] & MASK5;
		res[0] = {r, r[4:2]};
		res[1] = {g, g[5:4]};
		res[2] = {b, b[4:2]};
		return res;
	endfunction

	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [19:0] p;
		p = 20'(x) * 20'(RECIP3);
		return p[18:11];
	endfunction

	function automatic logic [7:0] div7(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'(RECIP7);
		return p[21:14];
	endfunction

	function automatic logic [7:0] div5(input logic [10:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'(RECIP5);
		return p[21:14];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dxt_front.sv
// Front half: accepts a compressed block, forms palette and ramp numerators,
// then divides them into a complete queue entry. Depends on dxt_pkg.
`default_nettype none

module dxt_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               alpha_mode,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [127:0]       s_tdata,
	output logic                    q_valid,
	input  wire logic               q_ready,
	output dxt_pkg::entry_t         q_entry
);

	logic [63:0] cw;
	logic [63:0] aw;
	dxt_pkg::rgb_t e0_c, e1_c;
	logic [2:0][9:0] n2_c, n3_c;
	logic [2:0][8:0] nh_c;
	logic [5:0][10:0] n7_c;
	logic [3:0][10:0] n5_c;

	logic v_s1;
	logic mode_s1, four_s1, agt_s1;
	dxt_pkg::rgb_t e0_s1, e1_s1;
	logic [2:0][9:0] n2_s1, n3_s1;
	logic [2:0][8:0] nh_s1;
	logic [5:0][10:0] n7_s1;
	logic [3:0][10:0] n5_s1;
	logic [7:0] a0_s1, a1_s1;
	logic [31:0] cidx_s1;
	logic [47:0] aidx_s1;

	assign cw = s_tdata[63:0];
	assign aw = s_tdata[127:64];

	// Endpoint widening and the numerators of every interpolated entry
	always_comb begin
		e0_c = dxt_pkg::widen565(cw[15:0]);
		e1_c = dxt_pkg::widen565(cw[31:16]);
		for (int ch = 0; ch < 3; ch++) begin
			n2_c[ch] = 10'({e0_c[ch], 1'b0}) + 10'(e1_c[ch]) + 10'd1;
			n3_c[ch] = 10'(e0_c[ch]) + 10'({e1_c[ch], 1'b0}) + 10'd1;
			nh_c[ch] = 9'(e0_c[ch]) + 9'(e1_c[ch]) + 9'd1;
		end
		for (int k = 1; k <= 6; k++) begin
			n7_c[k-1] = 11'(7 - k) * 11'(aw[7:0]) + 11'(k) * 11'(aw[15:8]);
		end
		for (int k = 1; k <= 4; k++) begin
			n5_c[k-1] = 11'(5 - k) * 11'(aw[7:0]) + 11'(k) * 11'(aw[15:8]);
		end
	end

	// Stage 1 holds one block until the queue takes it
	assign s_tready = !v_s1 || q_ready;
	assign q_valid = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1 <= alpha_mode;
			four_s1 <= alpha_mode || (cw[15:0] > cw[31:16]);
			agt_s1 <= aw[7:0] > aw[15:8];
			e0_s1 <= e0_c;
			e1_s1 <= e1_c;
			n2_s1 <= n2_c;
			n3_s1 <= n3_c;
			nh_s1 <= nh_c;
			n7_s1 <= n7_c;
			n5_s1 <= n5_c;
			a0_s1 <= aw[7:0];
			a1_s1 <= aw[15:8];
			cidx_s1 <= cw[63:32];
			aidx_s1 <= aw[63:16];
		end
	end

	// Reciprocal divides (or a halving in three-colour mode) complete the palette and alpha ramp
	always_comb begin
		q_entry.alpha_mode = mode_s1;
		q_entry.cidx = cidx_s1;
		q_entry.aidx = aidx_s1;
		q_entry.pal[0] = {dxt_pkg::ALPHA_OPAQUE, e0_s1};
		q_entry.pal[1] = {dxt_pkg::ALPHA_OPAQUE, e1_s1};
		if (four_s1) begin
			for (int ch = 0; ch < 3; ch++) begin
				q_entry.pal[2][ch*8 +: 8] = dxt_pkg::div3(n2_s1[ch]);
				q_entry.pal[3][ch*8 +: 8] = dxt_pkg::div3(n3_s1[ch]);
			end
			q_entry.pal[2][31:24] = dxt_pkg::ALPHA_OPAQUE;
			q_entry.pal[3][31:24] = dxt_pkg::ALPHA_OPAQUE;
		end else begin
			for (int ch = 0; ch < 3; ch++) begin
				q_entry.pal[2][ch*8 +: 8] = nh_s1[ch][8:1];
			end
			q_entry.pal[2][31:24] = dxt_pkg::ALPHA_OPAQUE;
			q_entry.pal[3] = {dxt_pkg::ALPHA_CLEAR, 24'd0};
		end
		q_entry.ramp[0] = a0_s1;
		q_entry.ramp[1] = a1_s1;
		if (agt_s1) begin
			for (int k = 1; k <= 6; k++) begin
				q_entry.ramp[k+1] = dxt_pkg::div7(n7_s1[k-1]);
			end
		end else begin
			for (int k = 1; k <= 4; k++) begin
				q_entry.ramp[k+1] = dxt_pkg::div5(n5_s1[k-1]);
			end
			q_entry.ramp[6] = dxt_pkg::ALPHA_CLEAR;
			q_entry.ramp[7] = dxt_pkg::ALPHA_OPAQUE;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/dxt_queue.sv
// Short first-in first-out queue of decoded blocks between front and back.
// Depends on dxt_pkg for the entry type.
`default_nettype none

module dxt_queue #(
	parameter int DEPTH = dxt_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire dxt_pkg::entry_t push_entry,
	output logic                 pop_valid,
	input  wire logic            pop,
	output dxt_pkg::entry_t      pop_entry
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	dxt_pkg::entry_t mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = count_q != CntW'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_entry = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;

	// Pointer and occupancy bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/dxt_back.sv
// Back half: walks the queue head row by row, selects palette and ramp
// entries per texel and drives the output register. Depends on dxt_pkg.
`default_nettype none

module dxt_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire dxt_pkg::entry_t head,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [135:0]         m_tdata,
	output logic                 m_tlast
);

	logic [1:0] row_q;
	logic m_tvalid_q;
	logic m_tlast_q;
	logic [1:0] row_out_q;
	logic [3:0][31:0] texels_q;
	logic [3:0][31:0] texels_c;
	logic advance;

	assign advance = head_valid && (!m_tvalid_q || m_tready);
	assign pop = advance && (row_q == dxt_pkg::ROW_LAST);

	// Per-texel palette and alpha selection for the current row
	always_comb begin
		logic [3:0] t;
		logic [1:0] sel;
		logic [2:0] asel;
		logic [31:0] pe;
		for (int col = 0; col < 4; col++) begin
			t = {row_q, 2'(col)};
			sel = head.cidx[{t, 1'b0} +: 2];
			asel = head.aidx[6'(t) * 6'd3 +: 3];
			pe = head.pal[sel];
			texels_c[col] = {head.alpha_mode ? head.ramp[asel] : pe[31:24], pe[23:0]};
		end
	end

	// Row counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (advance) begin
				row_q <= row_q + 2'd1;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			texels_q <= texels_c;
			row_out_q <= row_q;
			m_tlast_q <= row_q == dxt_pkg::ROW_LAST;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast = m_tlast_q;
	assign m_tdata = {6'd0, row_out_q, texels_q};

endmodule

`default_nettype wire

// File: hw/rtl/dxt_texture_block_decoder.sv
// DXT texture block decoder top level: front half, block queue, back half.
// A block is registered in the front half, written into the queue, then each row is registered at the output;
// the output carries one row a cycle while m_tready is high, four rows per block.
// The front accepts a new block each cycle until the queue is full.
// Reset (arst_n low, asynchronous) clears all valids, pointers, counters and
// has_alpha_block; payload registers are not reset. Depends on dxt_pkg.
`default_nettype none

module dxt_texture_block_decoder #(
	parameter int QueueDepth = dxt_pkg::QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic         cfg_wr_data,   // has_alpha_block
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,       // colour_word, alpha_word
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [135:0]      m_tdata,       // texel_a, texel_b, texel_c, texel_d, row_index
	output logic              m_tlast        // last_row
);

	logic has_alpha_q;
	logic f_valid, f_ready;
	dxt_pkg::entry_t f_entry;
	logic h_valid, h_pop;
	dxt_pkg::entry_t h_entry;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_alpha_q <= 1'b0;
		end else if (cfg_wr_en) begin
			has_alpha_q <= cfg_wr_data;
		end
	end

	dxt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.alpha_mode (has_alpha_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.q_valid    (f_valid),
		.q_ready    (f_ready),
		.q_entry    (f_entry)
	);

	dxt_queue #(
		.DEPTH (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_entry (f_entry),
		.pop_valid  (h_valid),
		.pop        (h_pop),
		.pop_entry  (h_entry)
	);

	dxt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (h_valid),
		.head       (h_entry),
		.pop        (h_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

	// The input only stalls while the queue is full
	a_stall_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> !f_ready)
		else $error("input stalled with room in the queue");

	// A block leaves the queue exactly as its final row is loaded
	a_pop_last: assert property (@(posedge clk) disable iff (!arst_n)
		h_pop |=> (m_tvalid && m_tlast))
		else $error("block popped without its final row");

	// tlast and the row number agree
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[129:128] == dxt_pkg::ROW_LAST)))
		else $error("tlast does not match the row number");

endmodule

`default_nettype wire

// File: verif/dxt_texture_block_decoder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for dxt_texture_block_decoder: directed and random 4x4 blocks
// in colour-only and alpha modes, with random stalls on both stream sides.
// Depends on dxt_pkg and the decoder RTL; needs no files or arguments.

module dxt_texture_block_decoder_tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int IDLE_PERCENT = 19;

	// One decoded row as the output stream carries it
	typedef struct packed {
		logic last;
		logic [1:0] row;
		logic [3:0][31:0] texel;
	} texel_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [127:0] s_tdata = '0;   // colour_word, alpha_word
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [135:0] m_tdata;        // texel_a, texel_b, texel_c, texel_d, row_index
	logic m_tlast;                // last_row

	texel_row_t expected_rows[$];
	bit alpha_mode_cfg = 1'b0;
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_off_request = 1'b0;
	int hold_left = 0;
	int mismatch_count = 0;
	int blocks_sent = 0;
	int rows_checked = 0;
	int quiet_cycles = 0;
	string texel_field[4] = '{"texel_a", "texel_b", "texel_c", "texel_d"};

	dxt_texture_block_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Bit-replicating widen of a 5- or 6-bit channel
	function automatic int stretch(input int v, input int bits);
		return (bits == 5) ? ((v << 3) | (v >> 2)) : ((v << 2) | (v >> 4));
	endfunction

	// Decode one block and queue its four rows
	function automatic void predict_rows(input logic [63:0] cw, input logic [63:0] aw,
			input bit amode);
		int e0[3];
		int e1[3];
		int pal[4][4];
		int ramp[8];
		int c0, c1, a0, a1, sel, asel, t;
		bit four;
		texel_row_t r;
		c0 = cw[15:0];
		c1 = cw[31:16];
		e0[0] = stretch((c0 >> 11) & 31, 5);
		e0[1] = stretch((c0 >> 5) & 63, 6);
		e0[2] = stretch(c0 & 31, 5);
		e1[0] = stretch((c1 >> 11) & 31, 5);
		e1[1] = stretch((c1 >> 5) & 63, 6);
		e1[2] = stretch(c1 & 31, 5);
		four = amode || (c0 > c1);
		for (int ch = 0; ch < 3; ch++) begin
			pal[0][ch] = e0[ch];
			pal[1][ch] = e1[ch];
			pal[2][ch] = four ? (2 * e0[ch] + e1[ch] + 1) / 3 : (e0[ch] + e1[ch] + 1) / 2;
			pal[3][ch] = four ? (e0[ch] + 2 * e1[ch] + 1) / 3 : 0;
		end
		pal[0][3] = 255;
		pal[1][3] = 255;
		pal[2][3] = 255;
		pal[3][3] = four ? 255 : 0;
		// alpha ramp: eight-step when a0 > a1, else six-step plus 0 and 255
		a0 = aw[7:0];
		a1 = aw[15:8];
		ramp[0] = a0;
		ramp[1] = a1;
		if (a0 > a1) begin
			for (int k = 1; k <= 6; k++)
				ramp[k + 1] = ((7 - k) * a0 + k * a1) / 7;
		end else begin
			for (int k = 1; k <= 4; k++)
				ramp[k + 1] = ((5 - k) * a0 + k * a1) / 5;
			ramp[6] = 0;
			ramp[7] = 255;
		end
		for (int row = 0; row < 4; row++) begin
			r.row = 2'(row);
			r.last = (2'(row) == dxt_pkg::ROW_LAST);
			for (int col = 0; col < 4; col++) begin
				t = row * 4 + col;
				sel = cw[32 + 2 * t +: 2];
				asel = aw[16 + 3 * t +: 3];
				r.texel[col] = {8'(amode ? ramp[asel] : pal[sel][3]), 8'(pal[sel][2]),
					8'(pal[sel][1]), 8'(pal[sel][0])};
			end
			expected_rows = {expected_rows, r};
		end
	endfunction

	// Output side: random stalls, or a counted hold-off on request
	always @(posedge clk) begin
		if (hold_off_request) begin
			hold_off_request = 1'b0;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else
			m_tready <= !(rx_gaps && $urandom_range(0, 99) < IDLE_PERCENT);
	end

	// Compare each row transaction with the oldest predicted row
	always @(posedge clk) begin : row_checker
		texel_row_t want;
		if (arst_n && m_tvalid && m_tready) begin
			rows_checked++;
			if (expected_rows.size() == 0) begin
				$error("row transaction with no block outstanding: %h", m_tdata);
				mismatch_count++;
			end else begin
				want = expected_rows.pop_front();
				for (int i = 0; i < 4; i++)
					if (m_tdata[32 * i +: 32] !== want.texel[i]) begin
						$error("%s expected %h got %h", texel_field[i], want.texel[i],
							m_tdata[32 * i +: 32]);
						mismatch_count++;
					end
				if (m_tdata[129:128] !== want.row) begin
					$error("row_index expected %0d got %0d", want.row, m_tdata[129:128]);
					mismatch_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last_row expected %0d got %0d", want.last, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Offer one block, hold it until accepted, then predict its rows
	task automatic send_block(input logic [63:0] cw, input logic [63:0] aw);
		while (tx_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {aw, cw};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_rows(cw, aw, alpha_mode_cfg);
		blocks_sent++;
	endtask

	// Stop sending and wait until every predicted row has arrived
	task automatic drain_decoder();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_alpha_mode(input bit v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		alpha_mode_cfg = v;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Alpha indices counting 0..7 across the sixteen texels
	function automatic logic [47:0] counting_alpha_indices();
		logic [47:0] idx;
		for (int t = 0; t < 16; t++)
			idx[3 * t +: 3] = 3'(t % 8);
		return idx;
	endfunction

	function automatic logic [63:0] random_colour_word();
		logic [63:0] cw;
		cw = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: cw[31:16] = cw[15:0];
			1: cw[15:0] = 16'hFFFF;
			2: cw[31:16] = 16'h0000;
			3: cw[15:0] = 16'h0000;
			default: ;
		endcase
		return cw;
	endfunction

	function automatic logic [63:0] random_alpha_word();
		logic [63:0] aw;
		aw = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: aw[15:8] = aw[7:0];
			1: aw[7:0] = 8'hFF;
			2: aw[15:8] = 8'h00;
			3: aw[7:0] = 8'h00;
			default: ;
		endcase
		return aw;
	endfunction

	// Colour-only mode: four-colour, three-colour with transparent black, equal endpoints
	task automatic test_colour_extremes();
		write_alpha_mode(1'b0);
		send_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, 64'h0);
		send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, 64'hFFFF_FFFF_FFFF_FFFF);
		send_block({32'h1B1B1B1B, 16'h1234, 16'h1234}, 64'h0);
		send_block(64'h0, 64'h0);
		send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_block({32'hE4E4E4E4, 16'h07E0, 16'hF800}, 64'h0);
		send_block({32'h4E4E4E4E, 16'h001F, 16'h0020}, 64'h0);
		drain_decoder();
	endtask

	// Alpha mode: both ramp kinds, equal endpoints, forced four-colour palette
	task automatic test_alpha_extremes();
		logic [47:0] idx;
		idx = counting_alpha_indices();
		write_alpha_mode(1'b1);
		send_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, {idx, 8'h00, 8'hFF});
		send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, {idx, 8'hFF, 8'h00});
		send_block({32'hE4E4E4E4, 16'h1234, 16'h1234}, {idx, 8'h80, 8'h80});
		send_block({32'hE4E4E4E4, 16'hF800, 16'h07E0}, {idx, 8'h10, 8'hC7});
		send_block(64'h0, 64'h0);
		send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_block({32'h1B1B1B1B, 16'hABCD, 16'h5432}, {~idx, 8'h37, 8'h02});
		drain_decoder();
	endtask

	task automatic test_colour_random();
		write_alpha_mode(1'b0);
		repeat (100) send_block(random_colour_word(), random_alpha_word());
		drain_decoder();
	endtask

	task automatic test_alpha_random();
		write_alpha_mode(1'b1);
		repeat (100) send_block(random_colour_word(), random_alpha_word());
		drain_decoder();
	endtask

	// Output held off while blocks keep coming, so the queue fills and the input stalls
	task automatic test_back_pressure();
		hold_off_request = 1'b1;
		repeat (16) send_block(random_colour_word(), random_alpha_word());
		drain_decoder();
	endtask

	// Full-rate stretch with no stalls on either side
	task automatic test_steady_stream();
		write_alpha_mode(1'b0);
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		repeat (40) send_block(random_colour_word(), random_alpha_word());
		drain_decoder();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	// Short bursts, each fully drained, switching mode in between
	task automatic test_paused_sender();
		for (int burst = 0; burst < 6; burst++) begin
			write_alpha_mode(burst[0]);
			repeat (5) send_block(random_colour_word(), random_alpha_word());
			drain_decoder();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_colour_extremes();
		test_alpha_extremes();
		test_colour_random();
		test_alpha_random();
		test_back_pressure();
		test_steady_stream();
		test_paused_sender();
		$display("Decoded %0d blocks into %0d rows, colour-only and alpha modes,",
			blocks_sent, rows_checked);
		$display("with random stalls, an output hold-off, a full-rate burst and drained pauses");
		if (mismatch_count == 0 && expected_rows.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: dxt_texture_block_decoder.f
hw/rtl/dxt_pkg.sv
hw/rtl/dxt_front.sv
hw/rtl/dxt_queue.sv
hw/rtl/dxt_back.sv
hw/rtl/dxt_texture_block_decoder.sv
verif/dxt_texture_block_decoder_tb.sv
